@@ rtl/core/slnf_pkg.sv @@
// Shared types, codes and glyph tables of the segment LCD number formatter.
`timescale 1ns / 1ps
package slnf_pkg;

   typedef struct packed {
      logic [2:0]  kind;
      logic [31:0] value;
      logic [1:0]  fraction_digits;
      logic [3:0]  digit_count;
      logic [15:0] annunciators;
      logic [4:0]  radix;
   } req_payload_type;

   typedef struct packed {
      logic [3:0] ram_address;
      logic [7:0] ram_byte;
      logic       last;
   } rsp_payload_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic start;
      logic split_mul;
      logic split_rem;
      logic plan;
      logic draw_minus;
      logic draw_digit;
      logic draw_flags;
      logic load_second;
      logic emit;
   } slnf_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic reject;
      logic direct;
      logic has_digits;
      logic split_last;
      logic grp_neg;
      logic digit_last;
      logic second_pending;
      logic emit_done;
   } slnf_sts_type;

   localparam logic [2:0] KIND_BLANK          = 3'd0;
   localparam logic [2:0] KIND_FULL           = 3'd1;
   localparam logic [2:0] KIND_SIGNED         = 3'd2;
   localparam logic [2:0] KIND_FIXED_UNSIGNED = 3'd3;
   localparam logic [2:0] KIND_FIXED_NEGATIVE = 3'd4;

   localparam logic [1:0] CSR_DOT_FLAG_BIT = 2'd0;
   localparam logic [1:0] CSR_LETTER_P_BIT = 2'd1;
   localparam logic [1:0] CSR_LETTER_I_BIT = 2'd2;
   localparam logic [1:0] CSR_LETTER_U_BIT = 2'd3;

   localparam logic [4:0] GLYPH_MINUS = 5'd16;
   localparam logic [4:0] GLYPH_P     = 5'd17;
   localparam logic [4:0] GLYPH_I     = 5'd18;
   localparam logic [4:0] GLYPH_U     = 5'd19;

   localparam int FLAG_SLOTS = 11;
   localparam logic [31:0] DIV10_RECIP = 32'hCCCC_CCCD;

   function automatic logic [7:0] glyph_bits(input logic [4:0] g);
      case (g)
         5'd0:    glyph_bits = 8'h7D;
         5'd1:    glyph_bits = 8'h60;
         5'd2:    glyph_bits = 8'h3E;
         5'd3:    glyph_bits = 8'h7A;
         5'd4:    glyph_bits = 8'h63;
         5'd5:    glyph_bits = 8'h5B;
         5'd6:    glyph_bits = 8'h5F;
         5'd7:    glyph_bits = 8'h70;
         5'd8:    glyph_bits = 8'h7F;
         5'd9:    glyph_bits = 8'h7B;
         5'd10:   glyph_bits = 8'h77;
         5'd11:   glyph_bits = 8'h4F;
         5'd12:   glyph_bits = 8'h1D;
         5'd13:   glyph_bits = 8'h6E;
         5'd14:   glyph_bits = 8'h1F;
         5'd15:   glyph_bits = 8'h17;
         5'd16:   glyph_bits = 8'h02;
         5'd17:   glyph_bits = 8'h37;
         5'd18:   glyph_bits = 8'h05;
         5'd19:   glyph_bits = 8'h6D;
         default: glyph_bits = 8'h00;
      endcase
   endfunction

   // Nibble address of glyph half idx: position (idx/2)+1, high half when idx is odd.
   function automatic logic [4:0] glyph_naddr(input logic [4:0] idx);
      case (idx)
         5'd0:    glyph_naddr = 5'h00;
         5'd1:    glyph_naddr = 5'h01;
         5'd2:    glyph_naddr = 5'h02;
         5'd3:    glyph_naddr = 5'h03;
         5'd4:    glyph_naddr = 5'h04;
         5'd5:    glyph_naddr = 5'h05;
         5'd6:    glyph_naddr = 5'h0D;
         5'd7:    glyph_naddr = 5'h0E;
         5'd8:    glyph_naddr = 5'h0F;
         5'd9:    glyph_naddr = 5'h10;
         5'd10:   glyph_naddr = 5'h11;
         5'd11:   glyph_naddr = 5'h12;
         5'd12:   glyph_naddr = 5'h13;
         5'd13:   glyph_naddr = 5'h1A;
         5'd14:   glyph_naddr = 5'h1B;
         5'd15:   glyph_naddr = 5'h1C;
         5'd16:   glyph_naddr = 5'h1D;
         5'd17:   glyph_naddr = 5'h1E;
         default: glyph_naddr = 5'h00;
      endcase
   endfunction

   function automatic logic [3:0] flag_nib(input logic [3:0] i);
      case (i)
         4'd0:    flag_nib = 4'h8;
         4'd1:    flag_nib = 4'h1;
         4'd2:    flag_nib = 4'h4;
         4'd3:    flag_nib = 4'h8;
         4'd4:    flag_nib = 4'h1;
         4'd5:    flag_nib = 4'h8;
         4'd6:    flag_nib = 4'h8;
         4'd7:    flag_nib = 4'h2;
         4'd8:    flag_nib = 4'h4;
         4'd9:    flag_nib = 4'h8;
         4'd10:   flag_nib = 4'h8;
         default: flag_nib = 4'h0;
      endcase
   endfunction

   function automatic logic [4:0] flag_naddr(input logic [3:0] i);
      case (i)
         4'd0:    flag_naddr = 5'h12;
         4'd1:    flag_naddr = 5'h1D;
         4'd2:    flag_naddr = 5'h1D;
         4'd3:    flag_naddr = 5'h1D;
         4'd4:    flag_naddr = 5'h1E;
         4'd5:    flag_naddr = 5'h1A;
         4'd6:    flag_naddr = 5'h1C;
         4'd7:    flag_naddr = 5'h1E;
         4'd8:    flag_naddr = 5'h1E;
         4'd9:    flag_naddr = 5'h01;
         4'd10:   flag_naddr = 5'h03;
         default: flag_naddr = 5'h00;
      endcase
   endfunction

   // Image-wide OR mask that places nibble n at nibble address a.
   function automatic logic [127:0] nib_mask(input logic [4:0] a, input logic [3:0] n);
      logic [127:0] m;
      m = '0;
      for (int k = 0; k < 32; k++) begin
         if (a == 5'(k)) begin
            m[k*4 +: 4] = n;
         end
      end
      return m;
   endfunction

endpackage

@@ rtl/core/slnf_ctrl.sv @@
// Sequencing state machine of the segment LCD number formatter.
`timescale 1ns / 1ps
module slnf_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   output slnf_pkg::slnf_cmd_type cmd,
   input  slnf_pkg::slnf_sts_type sts
);
   import slnf_pkg::*;

   typedef enum logic [8:0] {
      ST_IDLE  = 9'b000000001,
      ST_MUL   = 9'b000000010,
      ST_REM   = 9'b000000100,
      ST_PLAN  = 9'b000001000,
      ST_MINUS = 9'b000010000,
      ST_DIGIT = 9'b000100000,
      ST_FLAGS = 9'b001000000,
      ST_NEXT  = 9'b010000000,
      ST_EMIT  = 9'b100000000
   } state_type;

   state_type state_ff, state_in;
   logic      accept;

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && (state_ff == ST_IDLE);

   always_comb begin
      cmd             = '0;
      cmd.start       = accept;
      cmd.split_mul   = (state_ff == ST_MUL);
      cmd.split_rem   = (state_ff == ST_REM);
      cmd.plan        = (state_ff == ST_PLAN);
      cmd.draw_minus  = (state_ff == ST_MINUS);
      cmd.draw_digit  = (state_ff == ST_DIGIT);
      cmd.draw_flags  = (state_ff == ST_FLAGS);
      cmd.load_second = (state_ff == ST_NEXT);
      cmd.emit        = (state_ff == ST_EMIT);
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept && !sts.reject) begin
               if (sts.direct) begin
                  state_in = ST_EMIT;
               end else if (sts.has_digits) begin
                  state_in = ST_MUL;
               end else begin
                  state_in = ST_PLAN;
               end
            end
         end
         ST_MUL:   state_in = ST_REM;
         ST_REM:   state_in = sts.split_last ? ST_PLAN : ST_MUL;
         ST_PLAN:  state_in = sts.grp_neg ? ST_MINUS : ST_DIGIT;
         ST_MINUS: state_in = ST_DIGIT;
         ST_DIGIT: state_in = sts.digit_last ? ST_FLAGS : ST_DIGIT;
         ST_FLAGS: state_in = sts.second_pending ? ST_NEXT : ST_EMIT;
         ST_NEXT:  state_in = ST_DIGIT;
         ST_EMIT:  state_in = sts.emit_done ? ST_IDLE : ST_EMIT;
         default:  state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

@@ rtl/core/slnf_dp.sv @@
// Datapath of the segment LCD number formatter: digit split, placement, image and output.
`timescale 1ns / 1ps
module slnf_dp #(
   parameter int DIGIT_POSITIONS = 8
) (
   input  logic                     clock,
   input  logic                     reset,
   input  slnf_pkg::slnf_cmd_type   cmd,
   output slnf_pkg::slnf_sts_type   sts,
   input  slnf_pkg::req_payload_type req_payload,
   input  logic                     csr_write,
   input  logic [1:0]               csr_index,
   input  logic [3:0]               csr_data,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output slnf_pkg::rsp_payload_type rsp_payload
);
   import slnf_pkg::*;

   localparam int CNT_W = $clog2(DIGIT_POSITIONS + 1);
   localparam int IDX_W = (DIGIT_POSITIONS > 1) ? $clog2(DIGIT_POSITIONS) : 1;
   localparam int SW    = CNT_W + 2;
   localparam logic signed [SW-1:0] P_S   = SW'(DIGIT_POSITIONS);
   localparam logic signed [SW-1:0] TWO_S = SW'(2);

   logic [3:0] dot_ff, letp_ff, leti_ff, letu_ff;

   req_payload_type  pl_ff;
   logic [31:0]      mag_ff;
   logic [63:0]      prod_ff;
   logic [CNT_W-1:0] split_left_ff;
   logic [IDX_W-1:0] wr_idx_ff;
   logic [3:0]       scratch_ff [DIGIT_POSITIONS];
   logic             neg_ff;
   logic [CNT_W-1:0] int_ct_ff;
   logic [CNT_W-1:0] rd_idx_ff;
   logic [CNT_W-1:0] left_ff;
   logic [3:0]       pos_ff;
   logic [15:0]      gflags_ff;
   logic             second_ff;
   logic [127:0]     image_ff;
   logic [3:0]       addr_ff;
   rsp_payload_type  rsp_ff;
   logic             rsp_valid_ff;

   // Command decode at the input.
   logic             radix_ok, neg_s, fnz, reject, direct;
   logic signed [SW-1:0] ict_s;
   logic [CNT_W-1:0] count_s, ict_u;
   logic [31:0]      mag_s;

   always_comb begin
      radix_ok = (req_payload.radix == 5'd10) || (req_payload.radix == 5'd16);
      fnz      = (req_payload.fraction_digits != 2'd0);
      neg_s    = 1'b0;
      case (req_payload.kind)
         KIND_SIGNED:         neg_s = req_payload.value[31];
         KIND_FIXED_NEGATIVE: neg_s = 1'b1;
         default:             neg_s = 1'b0;
      endcase
      mag_s = neg_s ? (32'd0 - req_payload.value) : req_payload.value;
      ict_s = P_S - $signed({{(SW-1){1'b0}}, neg_s}) - (fnz ? TWO_S : '0);
      ict_u = ict_s[CNT_W-1:0];
      reject = 1'b0;
      direct = 1'b0;
      count_s = CNT_W'(req_payload.digit_count);
      case (req_payload.kind)
         KIND_BLANK: direct = 1'b1;
         KIND_FULL:  direct = 1'b1;
         KIND_SIGNED: begin
            reject  = !radix_ok || (req_payload.fraction_digits == 2'd3);
            direct  = !(ict_s > 0);
            count_s = ict_u + CNT_W'(req_payload.fraction_digits);
         end
         KIND_FIXED_UNSIGNED: begin
            reject = !radix_ok || (32'(req_payload.digit_count) >= DIGIT_POSITIONS);
         end
         KIND_FIXED_NEGATIVE: begin
            reject = !radix_ok || (32'(req_payload.digit_count) >= DIGIT_POSITIONS - 1) ||
                     !req_payload.value[31];
         end
         default: reject = 1'b1;
      endcase
   end

   // Digit extraction: base 16 by shift, base 10 by reciprocal multiply and correction.
   logic        hex;
   logic [31:0] quo;
   logic [31:0] q10;
   logic [3:0]  rem;

   always_comb begin
      hex = (pl_ff.radix == 5'd16);
      quo = hex ? {4'd0, mag_ff[31:4]} : {3'd0, prod_ff[63:35]};
      q10 = {quo[28:0], 3'd0} + {quo[30:0], 1'd0};
      rem = hex ? mag_ff[3:0] : 4'(mag_ff - q10);
   end

   // Leading zero search over the integer digits.
   logic [CNT_W-1:0] lz;
   always_comb begin
      lz = int_ct_ff - CNT_W'(1);
      for (int j = DIGIT_POSITIONS - 1; j >= 0; j--) begin
         if ((CNT_W'(j) < int_ct_ff) && (scratch_ff[j] != 4'd0)) begin
            lz = CNT_W'(j);
         end
      end
   end

   // Fixed-width placement start.
   logic [4:0] fix_span;
   always_comb begin
      if (pl_ff.kind == KIND_FIXED_NEGATIVE) begin
         fix_span = 5'(DIGIT_POSITIONS - 1) - {1'b0, pl_ff.digit_count};
      end else begin
         fix_span = 5'(DIGIT_POSITIONS) - {1'b0, pl_ff.digit_count};
      end
   end

   // Glyph and flag masks.
   logic [4:0]   glyph;
   logic [7:0]   gbits;
   logic [4:0]   gidx;
   logic [127:0] gmask, fmask;
   logic [15:0]  fint;

   always_comb begin
      glyph = cmd.draw_minus ? GLYPH_MINUS : {1'b0, scratch_ff[rd_idx_ff[IDX_W-1:0]]};
      gbits = glyph_bits(glyph);
      gidx  = {pos_ff - 4'd1, 1'b0};
      gmask = nib_mask(glyph_naddr(gidx), gbits[3:0]) |
              nib_mask(glyph_naddr(gidx | 5'd1), gbits[7:4]);
      fmask = '0;
      if (gflags_ff[letp_ff]) begin
         fmask = nib_mask(5'h00, 4'(glyph_bits(GLYPH_P))) |
                 nib_mask(5'h01, 4'(glyph_bits(GLYPH_P) >> 4));
      end else if (gflags_ff[leti_ff]) begin
         fmask = nib_mask(5'h00, 4'(glyph_bits(GLYPH_I))) |
                 nib_mask(5'h01, 4'(glyph_bits(GLYPH_I) >> 4));
      end else if (gflags_ff[letu_ff]) begin
         fmask = nib_mask(5'h00, 4'(glyph_bits(GLYPH_U))) |
                 nib_mask(5'h01, 4'(glyph_bits(GLYPH_U) >> 4));
      end
      for (int i = 0; i < FLAG_SLOTS; i++) begin
         if (gflags_ff[i]) begin
            fmask = fmask | nib_mask(flag_naddr(4'(i)), flag_nib(4'(i)));
         end
      end
      fint = pl_ff.annunciators & ~(16'd1 << dot_ff);
   end

   logic out_free, emit_load;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign emit_load = cmd.emit && out_free;

   always_comb begin
      sts                = '0;
      sts.reject         = reject;
      sts.direct         = direct;
      sts.has_digits     = (count_s != '0);
      sts.split_last     = (split_left_ff == CNT_W'(1));
      sts.grp_neg        = neg_ff;
      sts.digit_last     = (left_ff <= CNT_W'(1));
      sts.second_pending = second_ff;
      sts.emit_done      = emit_load && (addr_ff == 4'd15);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dot_ff  <= 4'd0;
         letp_ff <= 4'd11;
         leti_ff <= 4'd12;
         letu_ff <= 4'd13;
      end else if (csr_write) begin
         case (csr_index)
            CSR_DOT_FLAG_BIT: dot_ff  <= csr_data;
            CSR_LETTER_P_BIT: letp_ff <= csr_data;
            CSR_LETTER_I_BIT: leti_ff <= csr_data;
            CSR_LETTER_U_BIT: letu_ff <= csr_data;
            default:          dot_ff  <= dot_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         pl_ff         <= req_payload;
         neg_ff        <= neg_s;
         mag_ff        <= mag_s;
         split_left_ff <= count_s;
         wr_idx_ff     <= IDX_W'(count_s - CNT_W'(1));
         int_ct_ff     <= ict_u;
         addr_ff       <= 4'd0;
         image_ff      <= (req_payload.kind == KIND_FULL) ? '1 : '0;
         second_ff     <= 1'b0;
      end
      if (cmd.split_mul) begin
         prod_ff <= mag_ff * DIV10_RECIP;
      end
      if (cmd.split_rem) begin
         scratch_ff[wr_idx_ff] <= rem;
         mag_ff                <= quo;
         wr_idx_ff             <= wr_idx_ff - IDX_W'(1);
         split_left_ff         <= split_left_ff - CNT_W'(1);
      end
      if (cmd.plan) begin
         gflags_ff <= fint;
         if (pl_ff.kind == KIND_SIGNED) begin
            rd_idx_ff <= lz;
            left_ff   <= int_ct_ff - lz;
            pos_ff    <= (pl_ff.fraction_digits != 2'd0) ? (4'(lz) + 4'd1)
                                                         : (4'(lz >> 1) + 4'd1);
            second_ff <= (pl_ff.fraction_digits != 2'd0);
         end else begin
            rd_idx_ff <= '0;
            left_ff   <= CNT_W'(pl_ff.digit_count);
            pos_ff    <= 4'(fix_span >> 1) + 4'd1;
            second_ff <= 1'b0;
         end
      end
      if (cmd.draw_minus) begin
         image_ff <= image_ff | gmask;
         pos_ff   <= pos_ff + 4'd1;
      end
      if (cmd.draw_digit && (left_ff != '0)) begin
         image_ff  <= image_ff | gmask;
         pos_ff    <= pos_ff + 4'd1;
         rd_idx_ff <= rd_idx_ff + CNT_W'(1);
         left_ff   <= left_ff - CNT_W'(1);
      end
      if (cmd.draw_flags) begin
         image_ff <= image_ff | fmask;
      end
      if (cmd.load_second) begin
         rd_idx_ff <= int_ct_ff;
         left_ff   <= CNT_W'(pl_ff.fraction_digits);
         pos_ff    <= 4'(DIGIT_POSITIONS - 1);
         gflags_ff <= 16'd1 << dot_ff;
         neg_ff    <= 1'b0;
         second_ff <= 1'b0;
      end
      if (emit_load) begin
         rsp_ff.ram_address <= addr_ff;
         rsp_ff.ram_byte    <= image_ff[{addr_ff, 3'd0} +: 8];
         rsp_ff.last        <= (addr_ff == 4'd15);
         addr_ff            <= addr_ff + 4'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (emit_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

@@ rtl/core/segment_lcd_number_formatter_top.sv @@
// Top level of the segment LCD number formatter.
`timescale 1ns / 1ps
// Each accepted item is one display command; it clears a 16-byte segment image (or sets
// it for full), draws blank, full, a signed number with up to two fraction digits, or a
// fixed-width unsigned or negative number in base 10 or 16, ORs in annunciator flags and
// letter glyphs, and then sends all 16 image bytes as result items in ascending address
// order, the sixteenth marked last. Commands with an unsupported radix, fraction count,
// width, sign or kind are taken and produce nothing. One command at a time is in flight:
// the digit splitter does a 32 by 32 reciprocal multiply, then a correction step, for each
// digit; then come glyph and flag drawing and the output of one byte per cycle while the
// output is not stalled. A new command is taken as soon as the last byte is in the output
// register. The flag bit of the decimal point and of the P, I and U letters are set through
// the configuration port; the user must set them only while the block is idle, which the
// block itself does not enforce.
module segment_lcd_number_formatter_top #(
   parameter int DIGIT_POSITIONS = 8
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  slnf_pkg::req_payload_type req_payload,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output slnf_pkg::rsp_payload_type rsp_payload,
   input  logic                      csr_write,
   input  logic [1:0]                csr_index,
   input  logic [3:0]                csr_data
);
   import slnf_pkg::*;

   slnf_cmd_type cmd;
   slnf_sts_type sts;

   // The controller sequences split, placement and emission.
   slnf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .cmd       (cmd),
      .sts       (sts)
   );

   // The datapath holds the digits, the image and the output register.
   slnf_dp #(
      .DIGIT_POSITIONS (DIGIT_POSITIONS)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .sts         (sts),
      .req_payload (req_payload),
      .csr_write   (csr_write),
      .csr_index   (csr_index),
      .csr_data    (csr_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

   // A stalled result item stays valid and unchanged.
   a_hold_stalled: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_payload))
      else $error("stalled result item changed or dropped");

   // Within a frame, bytes follow one another without gaps and in address order.
   a_frame_order: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_payload.last && !rsp_stall |=>
         rsp_valid && (rsp_payload.ram_address == $past(rsp_payload.ram_address) + 4'd1))
      else $error("frame bytes out of order or interrupted");

   // A new command is only taken when no frame is partly sent.
   a_idle_no_frame: assert property (@(posedge clock) disable iff (reset)
      !req_stall |-> !(rsp_valid && !rsp_payload.last))
      else $error("input taken while a frame is still being sent");

endmodule

@@ dv/tb.sv @@
// Self-checking testbench of the segment LCD number formatter.
`timescale 1ns / 1ps
module tb;
   import slnf_pkg::*;

   localparam int NPOS = 8;

   // How the frame of a directed row is expected: worked out by the predictor,
   // no frame at all, or a frame read off at a glance.
   typedef enum logic [1:0] {
      FRAME_PREDICTED,
      FRAME_NONE,
      FRAME_ZEROS,
      FRAME_ONES
   } frame_style_type;

   typedef struct {
      req_payload_type cmd;
      frame_style_type style;
   } directed_row_type;

   // Segment patterns of digits 0..F, then minus, P, I and U.
   localparam logic [7:0] SEGMENTS [20] = '{
      8'h7D, 8'h60, 8'h3E, 8'h7A, 8'h63, 8'h5B, 8'h5F, 8'h70,
      8'h7F, 8'h7B, 8'h77, 8'h4F, 8'h1D, 8'h6E, 8'h1F, 8'h17,
      8'h02, 8'h37, 8'h05, 8'h6D};
   // Two nibble addresses per digit position, positions one to nine.
   localparam logic [4:0] POS_NIBBLE [18] = '{
      5'h00, 5'h01, 5'h02, 5'h03, 5'h04, 5'h05, 5'h0D, 5'h0E, 5'h0F,
      5'h10, 5'h11, 5'h12, 5'h13, 5'h1A, 5'h1B, 5'h1C, 5'h1D, 5'h1E};
   // Segment bit and nibble address of the eleven annunciator flags.
   localparam logic [3:0] ANN_BIT [11] = '{
      4'h8, 4'h1, 4'h4, 4'h8, 4'h1, 4'h8, 4'h8, 4'h2, 4'h4, 4'h8, 4'h8};
   localparam logic [4:0] ANN_NIBBLE [11] = '{
      5'h12, 5'h1D, 5'h1D, 5'h1D, 5'h1E, 5'h1A, 5'h1C, 5'h1E, 5'h1E, 5'h01, 5'h03};

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   req_payload_type req_payload = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   rsp_payload_type rsp_payload;
   logic csr_write = 1'b0;
   logic [1:0] csr_index = CSR_DOT_FLAG_BIT;
   logic [3:0] csr_data = '0;

   // The predictor's copy of the registers, the image and the digit scratch.
   logic [3:0] dot_bit = 4'd0;
   logic [3:0] p_bit = 4'd11;
   logic [3:0] i_bit = 4'd12;
   logic [3:0] u_bit = 4'd13;
   logic [7:0] lcd_image [16];
   logic [3:0] digit_buf [NPOS];

   rsp_payload_type frame_bytes_q [$];
   int failures = 0;
   bit calm = 1'b0;

   segment_lcd_number_formatter_top #(.DIGIT_POSITIONS(NPOS)) DUT (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_payload(req_payload),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_payload(rsp_payload),
      .csr_write  (csr_write),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always #6 clock = ~clock;

   // ---------------------------------------------------------------------
   // Predictor of the display frame.
   // ---------------------------------------------------------------------

   // OR a nibble into the image; odd nibble addresses are the high half of a byte.
   function automatic void or_nibble(logic [4:0] addr, logic [3:0] nib);
      if (addr[0]) begin
         lcd_image[addr[4:1]] = lcd_image[addr[4:1]] | {nib, 4'h0};
      end else begin
         lcd_image[addr[4:1]] = lcd_image[addr[4:1]] | {4'h0, nib};
      end
   endfunction

   function automatic void draw_glyph(int pos, int g);
      logic [7:0] bits;
      if (pos < 1 || pos > 9) begin
         return;
      end
      bits = SEGMENTS[g];
      or_nibble(POS_NIBBLE[(pos - 1) * 2], bits[3:0]);
      or_nibble(POS_NIBBLE[(pos - 1) * 2 + 1], bits[7:4]);
   endfunction

   // Only one letter is drawn; P wins over I, and I over U.
   function automatic void draw_annunciators(logic [15:0] f);
      if (f[p_bit]) begin
         draw_glyph(1, 17);
      end else if (f[i_bit]) begin
         draw_glyph(1, 18);
      end else if (f[u_bit]) begin
         draw_glyph(1, 19);
      end
      for (int k = 0; k < 11; k++) begin
         if (f[k]) begin
            or_nibble(ANN_NIBBLE[k], ANN_BIT[k]);
         end
      end
   endfunction

   // A group that would run off the panel is dropped along with its flags.
   function automatic void place_digits(int first, int len, int pos, logic [15:0] f,
                                        int neg);
      int cur;
      if (pos < 1 || pos > NPOS || len < 0) begin
         return;
      end
      if (pos + len - 1 + neg > NPOS || first < 0 || first + len > NPOS) begin
         return;
      end
      cur = pos;
      if (neg != 0) begin
         draw_glyph(cur, 16);
         cur++;
      end
      for (int k = 0; k < len; k++) begin
         draw_glyph(cur, int'(digit_buf[first + k]));
         cur++;
      end
      if (f != 16'h0) begin
         draw_annunciators(f);
      end
   endfunction

   function automatic void split_value(logic [31:0] mag, logic [31:0] base, int count);
      for (int k = 0; k < count && k < NPOS; k++) begin
         digit_buf[count - 1 - k] = 4'(mag % base);
         mag = mag / base;
      end
   endfunction

   function automatic void draw_signed(logic [31:0] v, int frac, logic [15:0] f,
                                       logic [31:0] base);
      int neg;
      logic [31:0] mag;
      int int_ct;
      int lead;
      int len;
      logic [15:0] dot_mask;
      neg = int'(v[31]);
      mag = v[31] ? 32'd0 - v : v;
      int_ct = NPOS - neg - ((frac != 0) ? 2 : 0);
      dot_mask = 16'h1 << dot_bit;
      if (int_ct < 1 || int_ct + frac > NPOS) begin
         return;
      end
      split_value(mag, base, int_ct + frac);
      lead = 0;
      while (lead < int_ct && digit_buf[lead] == 4'h0) begin
         lead++;
      end
      if (lead == int_ct) begin
         len = 1;
         digit_buf[0] = 4'h0;
      end else begin
         len = int_ct - lead;
         for (int k = 0; k < len; k++) begin
            digit_buf[k] = digit_buf[k + lead];
         end
      end
      if (frac != 0) begin
         place_digits(0, len, int_ct - len + 1, f & ~dot_mask, neg);
         place_digits(int_ct, frac, NPOS - 1, dot_mask, 0);
      end else begin
         place_digits(0, len, (int_ct - len) / 2 + 1, f & ~dot_mask, neg);
      end
   endfunction

   // Works out the frame of one command and queues its sixteen bytes.
   function automatic bit render_command(req_payload_type c);
      logic [31:0] base;
      logic [15:0] f_int;
      int size;
      bit radix_ok;
      base = 32'(c.radix);
      size = int'(c.digit_count);
      f_int = c.annunciators & ~(16'h1 << dot_bit);
      radix_ok = (c.radix == 5'd10 || c.radix == 5'd16);
      case (c.kind)
         KIND_BLANK: begin
            foreach (lcd_image[k]) lcd_image[k] = 8'h00;
         end
         KIND_FULL: begin
            foreach (lcd_image[k]) lcd_image[k] = 8'hFF;
         end
         KIND_SIGNED: begin
            if (!radix_ok || c.fraction_digits > 2'd2) begin
               return 1'b0;
            end
            foreach (lcd_image[k]) lcd_image[k] = 8'h00;
            draw_signed(c.value, int'(c.fraction_digits), c.annunciators, base);
         end
         KIND_FIXED_UNSIGNED: begin
            if (!radix_ok || size >= NPOS) begin
               return 1'b0;
            end
            split_value(c.value, base, size);
            foreach (lcd_image[k]) lcd_image[k] = 8'h00;
            place_digits(0, size, (NPOS - size) / 2 + 1, f_int, 0);
         end
         KIND_FIXED_NEGATIVE: begin
            if (!radix_ok || size >= NPOS - 1 || !c.value[31]) begin
               return 1'b0;
            end
            split_value(32'd0 - c.value, base, size);
            foreach (lcd_image[k]) lcd_image[k] = 8'h00;
            place_digits(0, size, (NPOS - 1 - size) / 2 + 1, f_int, 1);
         end
         default: begin
            return 1'b0;
         end
      endcase
      for (int k = 0; k < 16; k++) begin
         frame_bytes_q.push_back('{ram_address: 4'(k), ram_byte: lcd_image[k],
                                   last: (k == 15)});
      end
      return 1'b1;
   endfunction

   // ---------------------------------------------------------------------
   // Result side: random stalls and the field-by-field comparison.
   // ---------------------------------------------------------------------

   always @(posedge clock) begin
      rsp_stall <= calm ? 1'b0 : ($urandom_range(0, 99) < 11);
   end

   always @(posedge clock) begin
      rsp_payload_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (frame_bytes_q.size() == 0) begin
            $error("unexpected frame byte: address %0d byte %02h",
                   rsp_payload.ram_address, rsp_payload.ram_byte);
            failures++;
         end else begin
            want = frame_bytes_q.pop_front();
            if (rsp_payload.ram_address !== want.ram_address) begin
               $error("ram_address: expected %0d, got %0d",
                      want.ram_address, rsp_payload.ram_address);
               failures++;
            end
            if (rsp_payload.ram_byte !== want.ram_byte) begin
               $error("ram_byte: expected %02h, got %02h",
                      want.ram_byte, rsp_payload.ram_byte);
               failures++;
            end
            if (rsp_payload.last !== want.last) begin
               $error("last: expected %0b, got %0b", want.last, rsp_payload.last);
               failures++;
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // Command side.
   // ---------------------------------------------------------------------

   // Holds the command until it is taken. The stall read just after the edge is
   // the value that edge saw, so the loop ends on the accepting edge.
   task automatic send_command(req_payload_type c, frame_style_type style);
      req_valid <= 1'b1;
      req_payload <= c;
      do @(posedge clock); while (req_stall);
      case (style)
         FRAME_PREDICTED: begin
            void'(render_command(c));
         end
         FRAME_ZEROS, FRAME_ONES: begin
            for (int k = 0; k < 16; k++) begin
               frame_bytes_q.push_back('{ram_address: 4'(k),
                                         ram_byte: (style == FRAME_ONES) ? 8'hFF : 8'h00,
                                         last: (k == 15)});
            end
         end
         default: begin
         end
      endcase
      // Occasionally leave a gap before the next command.
      if (!calm && $urandom_range(0, 99) < 11) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
   endtask

   // Registers change only with the block idle. A rejected command makes no
   // bytes, so after the queue drains the task still waits before it writes.
   task automatic write_registers(logic [3:0] dot, logic [3:0] p, logic [3:0] i,
                                  logic [3:0] u);
      req_valid <= 1'b0;
      wait (frame_bytes_q.size() == 0);
      repeat (60) @(posedge clock);
      csr_write <= 1'b1;
      csr_index <= CSR_DOT_FLAG_BIT;
      csr_data <= dot;
      @(posedge clock);
      csr_index <= CSR_LETTER_P_BIT;
      csr_data <= p;
      @(posedge clock);
      csr_index <= CSR_LETTER_I_BIT;
      csr_data <= i;
      @(posedge clock);
      csr_index <= CSR_LETTER_U_BIT;
      csr_data <= u;
      @(posedge clock);
      csr_write <= 1'b0;
      dot_bit = dot;
      p_bit = p;
      i_bit = i;
      u_bit = u;
   endtask

   // A random command, mostly well formed, with some broken ones mixed in.
   function automatic req_payload_type random_command();
      req_payload_type c;
      int pick;
      c.value = $urandom();
      case ($urandom_range(0, 3))
         0: c.value = $urandom_range(0, 999);
         1: c.value = 32'd0 - $urandom_range(1, 999);
         default: begin
         end
      endcase
      c.annunciators = ($urandom_range(0, 2) == 0) ? 16'h0 : 16'($urandom());
      c.radix = ($urandom_range(0, 1) != 0) ? 5'd10 : 5'd16;
      c.fraction_digits = 2'($urandom_range(0, 2));
      c.digit_count = 4'($urandom_range(0, 7));
      pick = $urandom_range(0, 99);
      if (pick < 5) begin
         c.kind = KIND_BLANK;
      end else if (pick < 10) begin
         c.kind = KIND_FULL;
      end else if (pick < 55) begin
         c.kind = KIND_SIGNED;
      end else if (pick < 72) begin
         c.kind = KIND_FIXED_UNSIGNED;
      end else if (pick < 90) begin
         c.kind = KIND_FIXED_NEGATIVE;
         c.value[31] = ($urandom_range(0, 9) != 0);
         c.digit_count = 4'($urandom_range(0, 6));
      end else begin
         // Noise: any kind, any radix, any width.
         c.kind = 3'($urandom_range(0, 7));
         c.radix = 5'($urandom_range(0, 31));
         c.fraction_digits = 2'($urandom_range(0, 3));
         c.digit_count = 4'($urandom_range(0, 15));
      end
      return c;
   endfunction

   directed_row_type directed_rows [] = '{
      '{'{KIND_BLANK, 32'hFFFF_FFFF, 2'd3, 4'd15, 16'hFFFF, 5'd31}, FRAME_ZEROS},
      '{'{KIND_FULL, 32'h0, 2'd0, 4'd0, 16'h0, 5'd0}, FRAME_ONES},
      '{'{KIND_SIGNED, 32'h0, 2'd0, 4'd0, 16'h0, 5'd10}, FRAME_PREDICTED},
      '{'{KIND_SIGNED, 32'h7FFF_FFFF, 2'd0, 4'd0, 16'h0, 5'd16}, FRAME_PREDICTED},
      '{'{KIND_SIGNED, 32'h8000_0000, 2'd2, 4'd0, 16'h0001, 5'd10}, FRAME_PREDICTED},
      '{'{KIND_SIGNED, 32'hFFFF_FFFB, 2'd1, 4'd0, 16'hFFFF, 5'd10}, FRAME_PREDICTED},
      '{'{KIND_SIGNED, 32'd12345, 2'd2, 4'd0, 16'h3800, 5'd10}, FRAME_PREDICTED},
      '{'{KIND_SIGNED, 32'd7, 2'd0, 4'd0, 16'h3000, 5'd16}, FRAME_PREDICTED},
      '{'{KIND_SIGNED, 32'd42, 2'd0, 4'd0, 16'h2000, 5'd10}, FRAME_PREDICTED},
      '{'{KIND_FIXED_UNSIGNED, 32'd0, 2'd0, 4'd0, 16'h07FF, 5'd10}, FRAME_PREDICTED},
      '{'{KIND_FIXED_UNSIGNED, 32'hFFFF_FFFF, 2'd0, 4'd7, 16'h0, 5'd16}, FRAME_PREDICTED},
      '{'{KIND_FIXED_UNSIGNED, 32'd9, 2'd0, 4'd3, 16'h0, 5'd10}, FRAME_PREDICTED},
      '{'{KIND_FIXED_NEGATIVE, 32'h8000_0000, 2'd0, 4'd6, 16'h0, 5'd10}, FRAME_PREDICTED},
      '{'{KIND_FIXED_NEGATIVE, 32'hFFFF_FFFF, 2'd0, 4'd0, 16'hC000, 5'd16},
        FRAME_PREDICTED},
      '{'{KIND_SIGNED, 32'd5, 2'd0, 4'd0, 16'h0, 5'd11}, FRAME_NONE},
      '{'{KIND_SIGNED, 32'd5, 2'd3, 4'd0, 16'h0, 5'd10}, FRAME_NONE},
      '{'{KIND_FIXED_UNSIGNED, 32'd5, 2'd0, 4'd8, 16'h0, 5'd10}, FRAME_NONE},
      '{'{KIND_FIXED_NEGATIVE, 32'hFFFF_FFFF, 2'd0, 4'd7, 16'h0, 5'd10}, FRAME_NONE},
      '{'{KIND_FIXED_NEGATIVE, 32'd5, 2'd0, 4'd2, 16'h0, 5'd10}, FRAME_NONE},
      '{'{3'd5, 32'd5, 2'd0, 4'd2, 16'h0, 5'd10}, FRAME_NONE},
      '{'{3'd7, 32'd5, 2'd0, 4'd2, 16'h0, 5'd16}, FRAME_NONE}
   };

   initial begin
      logic [3:0] phase_regs [4][4];
      phase_regs = '{'{4'd0, 4'd11, 4'd12, 4'd13},
                     '{4'd15, 4'd0, 4'd0, 4'd0},
                     '{4'd1, 4'd1, 4'd2, 4'd3},
                     '{4'd10, 4'd15, 4'd14, 4'd15}};
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed commands with the registers at their reset values.
      foreach (directed_rows[r]) begin
         send_command(directed_rows[r].cmd, directed_rows[r].style);
      end

      // Random commands under several register settings; the third phase
      // runs without any gaps or stalls.
      for (int ph = 0; ph < 4; ph++) begin
         if (ph < 3) begin
            write_registers(phase_regs[ph][0], phase_regs[ph][1], phase_regs[ph][2],
                            phase_regs[ph][3]);
         end else begin
            write_registers(4'($urandom()), 4'($urandom()), 4'($urandom()),
                            4'($urandom()));
         end
         calm = (ph == 2);
         repeat (90) begin
            send_command(random_command(), FRAME_PREDICTED);
         end
         calm = 1'b0;
      end
      req_valid <= 1'b0;

      // Drain, then give the block time to show any stray bytes.
      wait (frame_bytes_q.size() == 0);
      repeat (80) @(posedge clock);
      if (failures == 0 && frame_bytes_q.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

   // Guard against a hung handshake.
   initial begin
      #10ms;
      $display("CHECK FAILED");
      $finish;
   end

endmodule
